[rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ACBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ACBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/acbd_pkg.sv]
// Shared types and constants for the chunked body decoder.
`default_nettype none

package acbd_pkg;

    // Framing characters
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    // Bits per hex digit of the size field (radix 16)
    localparam int HEX_BITS = 4;

    // Default queue depths
    localparam int ACBD_CMD_DEPTH = 4;
    localparam int ACBD_RES_DEPTH = 4;

    // Result kinds
    localparam logic [1:0] RK_PAYLOAD  = 2'd0;
    localparam logic [1:0] RK_FINISHED = 2'd1;
    localparam logic [1:0] RK_ERROR    = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_SIZE  = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
    localparam logic [1:0] ERR_CHUNK_END = 2'd3;

    // Classified input byte, front to back
    typedef struct packed {
        logic                restart;
        logic                is_hex;
        logic [HEX_BITS-1:0] hex_val;
        logic                is_cr;
        logic                is_lf;
        logic                is_semi;
        logic [7:0]          data;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload;
        logic       chunk_end;
        logic [1:0] fault_code;
    } res_t;

endpackage

`default_nettype wire

[rtl/acbd_queue.sv]
// Small first-word-fall-through queue of register entries.
`default_nettype none

module acbd_queue #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[rtl/acbd_front.sv]
// Front end: classifies each incoming byte and queues it for the sequencer.
`default_nettype none

module acbd_front #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic          restart,
    input  logic [7:0]    data_byte,
    input  logic          cmd_pop,
    output logic          cmd_valid,
    output acbd_pkg::cmd_t cmd
);
    import acbd_pkg::*;

    cmd_t cmd_in;
    logic cmd_empty;

    // Hex digit decode, upper and lower case
    always_comb
    begin
        cmd_in         = '0;
        cmd_in.restart = restart;
        cmd_in.data    = data_byte;
        cmd_in.is_cr   = (data_byte == CH_CR);
        cmd_in.is_lf   = (data_byte == CH_LF);
        cmd_in.is_semi = (data_byte == CH_SEMI);
        if (data_byte >= 8'h30 && data_byte <= 8'h39)
        begin
            cmd_in.is_hex  = 1'b1;
            cmd_in.hex_val = data_byte[HEX_BITS-1:0];
        end
        else if ((data_byte >= 8'h41 && data_byte <= 8'h46) ||
                 (data_byte >= 8'h61 && data_byte <= 8'h66))
        begin
            cmd_in.is_hex  = 1'b1;
            cmd_in.hex_val = data_byte[HEX_BITS-1:0] + HEX_BITS'(9);
        end
    end

    // Queue between front and back
    acbd_queue #(
        .DEPTH (DEPTH),
        .WIDTH ($bits(cmd_t))
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd),
        .full    (full),
        .empty   (cmd_empty)
    );

    assign cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

[rtl/acbd_back.sv]
// Back end: framing sequencer and result queue.
`default_nettype none

module acbd_back #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  acbd_pkg::cmd_t cmd,
    output logic           cmd_pop,
    input  logic           pop,
    output logic           empty,
    output acbd_pkg::res_t result
);
    import acbd_pkg::*;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_SIZE_LF,
        PH_EXT,
        PH_EXT_CR,
        PH_DATA,
        PH_END_CR,
        PH_END_LF,
        PH_HALT
    } phase_t;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [63:0] remaining_reg, remaining_next, remaining_cur;
    logic        has_digit_reg, has_digit_next, has_digit_cur;
    logic [63:0] remaining_dec;
    logic        take;
    logic        res_wr;
    res_t        res_in;
    logic        res_full;

    assign take          = cmd_valid && !res_full;
    assign cmd_pop       = take;
    assign remaining_dec = remaining_cur - 64'd1;

    // Restart takes effect before the byte is processed
    always_comb
    begin
        phase_cur     = cmd.restart ? PH_SIZE : phase_reg;
        remaining_cur = cmd.restart ? 64'd0 : remaining_reg;
        has_digit_cur = cmd.restart ? 1'b0 : has_digit_reg;
    end

    // Sequencer step
    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        has_digit_next = has_digit_reg;
        res_wr         = 1'b0;
        res_in         = '0;
        if (take)
        begin
            phase_next     = phase_cur;
            remaining_next = remaining_cur;
            has_digit_next = has_digit_cur;
            case (phase_cur)
                PH_SIZE:
                begin
                    if (cmd.is_hex)
                    begin
                        if (remaining_cur[63:60] != '0)
                        begin
                            phase_next        = PH_HALT;
                            res_wr            = 1'b1;
                            res_in.kind       = RK_ERROR;
                            res_in.fault_code = ERR_OVERFLOW;
                        end
                        else
                        begin
                            remaining_next = {remaining_cur[59:0], cmd.hex_val};
                            has_digit_next = 1'b1;
                        end
                    end
                    else if (has_digit_cur && cmd.is_semi)
                    begin
                        phase_next = PH_EXT;
                    end
                    else if (has_digit_cur && cmd.is_cr)
                    begin
                        phase_next = PH_SIZE_LF;
                    end
                    else
                    begin
                        phase_next        = PH_HALT;
                        res_wr            = 1'b1;
                        res_in.kind       = RK_ERROR;
                        res_in.fault_code = ERR_BAD_SIZE;
                    end
                end
                PH_SIZE_LF, PH_EXT_CR:
                begin
                    if (cmd.is_lf)
                    begin
                        // size line done: zero ends the stream
                        if (remaining_cur == '0)
                        begin
                            phase_next  = PH_HALT;
                            res_wr      = 1'b1;
                            res_in.kind = RK_FINISHED;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                    else if (phase_cur == PH_SIZE_LF)
                    begin
                        phase_next        = PH_HALT;
                        res_wr            = 1'b1;
                        res_in.kind       = RK_ERROR;
                        res_in.fault_code = ERR_BAD_SIZE;
                    end
                    else if (!cmd.is_cr)
                    begin
                        phase_next = PH_EXT;
                    end
                end
                PH_EXT:
                begin
                    if (cmd.is_cr)
                    begin
                        phase_next = PH_EXT_CR;
                    end
                end
                PH_DATA:
                begin
                    remaining_next   = remaining_dec;
                    res_wr           = 1'b1;
                    res_in.kind      = RK_PAYLOAD;
                    res_in.payload   = cmd.data;
                    res_in.chunk_end = (remaining_dec == '0);
                    if (remaining_dec == '0)
                    begin
                        phase_next = PH_END_CR;
                    end
                end
                PH_END_CR:
                begin
                    if (cmd.is_cr)
                    begin
                        phase_next = PH_END_LF;
                    end
                    else
                    begin
                        phase_next        = PH_HALT;
                        res_wr            = 1'b1;
                        res_in.kind       = RK_ERROR;
                        res_in.fault_code = ERR_CHUNK_END;
                    end
                end
                PH_END_LF:
                begin
                    if (cmd.is_lf)
                    begin
                        phase_next     = PH_SIZE;
                        remaining_next = '0;
                        has_digit_next = 1'b0;
                    end
                    else
                    begin
                        phase_next        = PH_HALT;
                        res_wr            = 1'b1;
                        res_in.kind       = RK_ERROR;
                        res_in.fault_code = ERR_CHUNK_END;
                    end
                end
                default:
                begin
                    // halted: drop bytes until restart
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SIZE;
            remaining_reg <= '0;
            has_digit_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            has_digit_reg <= has_digit_next;
        end
    end

    // Result queue toward the consumer
    acbd_queue #(
        .DEPTH (DEPTH),
        .WIDTH ($bits(res_t))
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (result),
        .full    (res_full),
        .empty   (empty)
    );

endmodule

`default_nettype wire

[rtl/aws_chunked_body_decoder.sv]
// Chunked body decoder: one raw byte in, at most one result out.
//
// Input channel: drive restart and data_byte with push; a byte transfers on a
// rising edge with push high and full low. restart=1 returns the decoder to
// expect a chunk size before that byte is parsed.
// Result channel: while empty is low the oldest result sits on result_kind,
// payload_byte, chunk_end and fault_code; it transfers on an edge with pop
// high. Kinds: payload byte (chunk_end on the last byte of a chunk), stream
// finished, framing error with its code. Size, CR/LF and extension bytes
// give no result unless they finish the stream or raise an error.
// Path: a byte is held in the command queue, and its result in the result queue.
// Throughput: one byte per cycle while the result queue has room, set by the
// sequencer step (one 64-bit decrement and compare); the command queue and the
// result queue let the input keep flowing while a result waits.
// Reset: both queues empty, decoder expecting size digits.
// Receiver stall: results pile up in the result queue; once it is full the
// sequencer holds, the command queue fills, and full rises.
`default_nettype none

module aws_chunked_body_decoder #(
    parameter int CMD_DEPTH = acbd_pkg::ACBD_CMD_DEPTH,
    parameter int RES_DEPTH = acbd_pkg::ACBD_RES_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       restart,
    input  logic [7:0] data_byte,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] result_kind,
    output logic [7:0] payload_byte,
    output logic       chunk_end,
    output logic [1:0] fault_code
);
    import acbd_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;
    res_t result;

    acbd_front #(
        .DEPTH (CMD_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .restart   (restart),
        .data_byte (data_byte),
        .cmd_pop   (cmd_pop),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    acbd_back #(
        .DEPTH (RES_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    assign result_kind  = result.kind;
    assign payload_byte = result.payload;
    assign chunk_end    = result.chunk_end;
    assign fault_code   = result.fault_code;

endmodule

`default_nettype wire

[rtl/acbd_checker.sv]
// Port-level checker for the chunked body decoder, with its bind.
`default_nettype none
`include "assert_macros.svh"

module acbd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic       restart,
    input wire logic [7:0] data_byte,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [1:0] result_kind,
    input wire logic [7:0] payload_byte,
    input wire logic       chunk_end,
    input wire logic [1:0] fault_code
);
    import acbd_pkg::*;

    // Payload results carry no error code
    `ACBD_ASSERT_NOW(a_payload_clean, !empty && result_kind == RK_PAYLOAD, fault_code == ERR_NONE, "payload result with error code")

    // Error results carry a code and no payload fields
    `ACBD_ASSERT_NOW(a_error_fields, !empty && result_kind == RK_ERROR, fault_code != ERR_NONE && payload_byte == 8'd0 && !chunk_end, "malformed error result")

    // Finished results are bare, and no unused kind appears
    `ACBD_ASSERT_NOW(a_kind_legal, !empty && result_kind != RK_PAYLOAD && result_kind != RK_ERROR, result_kind == RK_FINISHED && fault_code == ERR_NONE && payload_byte == 8'd0 && !chunk_end, "bad finished or unknown kind")

    // A waiting result holds until it transfers
    `ACBD_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(result_kind) && $stable(payload_byte) && $stable(chunk_end) && $stable(fault_code), "result changed while stalled")

endmodule

bind aws_chunked_body_decoder acbd_checker u_acbd_checker (.*);

`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the chunked body decoder: directed table, then random streams.
`timescale 1ns / 1ps

module testbench;

    import acbd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LIVE_TARGET = 1850;
    localparam int DRAIN_CYCLES = 10;

    // Decoder phases as tracked by the predictor
    typedef enum logic [2:0] {
        DS_SIZE, DS_SIZE_LF, DS_EXT, DS_EXT_CR, DS_DATA, DS_END_CR, DS_END_LF, DS_HALT
    } dec_state_t;

    // One row of the directed table: byte, repeat count, optional fixed expectation
    typedef struct packed {
        logic       rs;
        logic [7:0] b;
        logic [7:0] reps;
        logic       typed;
        res_t       want;
    } row_t;

    localparam res_t NO_RES        = '0;
    localparam res_t BAD_SIZE_RES  = '{RK_ERROR, 8'h00, 1'b0, ERR_BAD_SIZE};
    localparam res_t OVERFLOW_RES  = '{RK_ERROR, 8'h00, 1'b0, ERR_OVERFLOW};
    localparam res_t CHUNK_END_RES = '{RK_ERROR, 8'h00, 1'b0, ERR_CHUNK_END};
    localparam res_t FINISHED_RES  = '{RK_FINISHED, 8'h00, 1'b0, ERR_NONE};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       restart = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [1:0] result_kind;
    logic [7:0] payload_byte;
    logic       chunk_end;
    logic [1:0] fault_code;

    // Predictor state
    dec_state_t dec_state = DS_SIZE;
    logic [63:0] size_acc = '0;
    logic [4:0]  digits_seen = '0;

    res_t awaited_results [$];
    logic [7:0] stream_bytes [$];
    row_t plan [27];
    int error_count = 0;
    int live_items = 0;
    int cycles = 0;
    bit steady = 1'b0;

    aws_chunked_body_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .restart      (restart),
        .data_byte    (data_byte),
        .empty        (empty),
        .pop          (pop),
        .result_kind  (result_kind),
        .payload_byte (payload_byte),
        .chunk_end    (chunk_end),
        .fault_code   (fault_code)
    );

    always #5 clk = ~clk;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Size line complete: zero size ends the stream, otherwise payload follows
    function automatic bit close_size_line(output res_t res);
        res = NO_RES;
        if (size_acc == 0)
        begin
            dec_state = DS_HALT;
            res = FINISHED_RES;
            return 1'b1;
        end
        dec_state = DS_DATA;
        return 1'b0;
    endfunction

    function automatic res_t halt_on(input logic [1:0] code);
        dec_state = DS_HALT;
        return '{RK_ERROR, 8'h00, 1'b0, code};
    endfunction

    // Advance the predictor by one byte; returns 1 when the byte yields a result
    function automatic bit decode_byte(input logic rs, input logic [7:0] c, output res_t res);
        int nib;
        bit has;
        res = NO_RES;
        has = 1'b0;
        nib = -1;
        if (rs)
        begin
            dec_state = DS_SIZE;
            size_acc = '0;
            digits_seen = '0;
        end
        if (c >= "0" && c <= "9") nib = c - "0";
        else if (c >= "A" && c <= "F") nib = c - "A" + 10;
        else if (c >= "a" && c <= "f") nib = c - "a" + 10;
        case (dec_state)
            DS_SIZE:
            begin
                if (nib >= 0)
                begin
                    if (size_acc[63:60] != 0)
                    begin
                        res = halt_on(ERR_OVERFLOW);
                        has = 1'b1;
                    end
                    else
                    begin
                        size_acc = {size_acc[59:0], 4'(nib)};
                        if (digits_seen != 5'd31) digits_seen++;
                    end
                end
                else if (digits_seen == 0 || (c != CH_SEMI && c != CH_CR))
                begin
                    res = halt_on(ERR_BAD_SIZE);
                    has = 1'b1;
                end
                else if (c == CH_SEMI) dec_state = DS_EXT;
                else dec_state = DS_SIZE_LF;
            end
            DS_SIZE_LF:
            begin
                if (c != CH_LF)
                begin
                    res = halt_on(ERR_BAD_SIZE);
                    has = 1'b1;
                end
                else has = close_size_line(res);
            end
            DS_EXT:
            begin
                if (c == CH_CR) dec_state = DS_EXT_CR;
            end
            DS_EXT_CR:
            begin
                if (c == CH_LF) has = close_size_line(res);
                else if (c != CH_CR) dec_state = DS_EXT;
            end
            DS_DATA:
            begin
                size_acc--;
                res = '{RK_PAYLOAD, c, size_acc == 0, ERR_NONE};
                if (size_acc == 0) dec_state = DS_END_CR;
                has = 1'b1;
            end
            DS_END_CR:
            begin
                if (c != CH_CR)
                begin
                    res = halt_on(ERR_CHUNK_END);
                    has = 1'b1;
                end
                else dec_state = DS_END_LF;
            end
            DS_END_LF:
            begin
                if (c != CH_LF)
                begin
                    res = halt_on(ERR_CHUNK_END);
                    has = 1'b1;
                end
                else
                begin
                    dec_state = DS_SIZE;
                    size_acc = '0;
                    digits_seen = '0;
                end
            end
            default:
            begin
            end
        endcase
        return has;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 10) return "0" + n;
        return 8'((upper ? "A" : "a") + n - 10);
    endfunction

    // Drive one byte, hold it until transferred, then log what it should produce
    task automatic send_byte(input logic rs, input logic [7:0] b, input bit typed,
                             input res_t want);
        res_t got;
        bit has;
        while (!steady && $urandom_range(99) < 22)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        restart <= rs;
        data_byte <= b;
        @(posedge clk);
        while (full) @(posedge clk);
        live_items++;
        has = decode_byte(rs, b, got);
        if (typed)
        begin
            if (!has || got != want)
                report_error($sformatf("table row for byte %02h disagrees with decode", b));
            awaited_results.push_back(want);
        end
        else if (has) awaited_results.push_back(got);
    endtask

    task automatic wait_all_results();
        push <= 1'b0;
        do @(posedge clk); while (awaited_results.size() != 0);
    endtask

    // One random stream: mostly well-formed chunks, some overflow, noise or huge sizes
    task automatic make_stream();
        int nchunks, sel, nlead, ndig, nbytes;
        logic [63:0] sz;
        bit upper, huge;
        stream_bytes = {};
        if ($urandom_range(99) < 5)
        begin
            repeat ($urandom_range(1, 8)) stream_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        nchunks = $urandom_range(1, 4);
        for (int k = 0; k <= nchunks; k++)
        begin
            sel = $urandom_range(99);
            upper = 1'($urandom_range(1));
            huge = 1'b0;
            nlead = ($urandom_range(9) == 0) ? $urandom_range(1, 35) : $urandom_range(0, 1);
            repeat (nlead) stream_bytes.push_back("0");
            if (k == nchunks) sz = 0;
            else if (sel < 70) sz = $urandom_range(1, 6);
            else if (sel < 92) sz = $urandom_range(7, 40);
            else if (sel < 97)
            begin
                sz = {$urandom, $urandom};
                huge = 1'b1;
            end
            else
            begin
                // more significant digits than 64 bits can hold
                stream_bytes.push_back(hex_char(4'($urandom_range(1, 15)), upper));
                repeat ($urandom_range(16, 18))
                    stream_bytes.push_back(hex_char(4'($urandom_range(0, 15)), upper));
                return;
            end
            ndig = 16;
            while (ndig > 1 && sz[4*ndig-1 -: 4] == 0) ndig--;
            for (int d = ndig - 1; d >= 0; d--)
                stream_bytes.push_back(hex_char(sz[4*d +: 4], upper));
            // extension bytes are skipped unchecked
            if ($urandom_range(99) < 30)
            begin
                stream_bytes.push_back(CH_SEMI);
                repeat ($urandom_range(0, 6)) stream_bytes.push_back(8'($urandom_range(0, 255)));
            end
            stream_bytes.push_back(CH_CR);
            stream_bytes.push_back(CH_LF);
            if (sz == 0) return;
            nbytes = huge ? 3 : int'(sz);
            repeat (nbytes) stream_bytes.push_back(8'($urandom_range(0, 255)));
            if (huge) return;
            stream_bytes.push_back(CH_CR);
            stream_bytes.push_back(CH_LF);
        end
    endtask

    // Result side: check each transfer against the oldest expectation, stall at random
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (awaited_results.size() == 0)
                    report_error($sformatf("unexpected result kind %0d payload %02h",
                                           result_kind, payload_byte));
                else
                begin
                    want = awaited_results.pop_front();
                    if (result_kind !== want.kind)
                        report_error($sformatf("result_kind %0d, expected %0d",
                                               result_kind, want.kind));
                    if (payload_byte !== want.payload)
                        report_error($sformatf("payload_byte %02h, expected %02h",
                                               payload_byte, want.payload));
                    if (chunk_end !== want.chunk_end)
                        report_error($sformatf("chunk_end %0b, expected %0b",
                                               chunk_end, want.chunk_end));
                    if (fault_code !== want.fault_code)
                        report_error($sformatf("fault_code %0d, expected %0d",
                                               fault_code, want.fault_code));
                end
            end
            pop <= steady || ($urandom_range(99) >= 22);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int streams;
        logic rs;
        streams = 0;
        // directed: error codes, empty size, extensions, leading zeros, overflow, end
        plan = '{
            '{1'b1, "g",     8'd1,  1'b1, BAD_SIZE_RES},
            '{1'b1, CH_SEMI, 8'd1,  1'b1, BAD_SIZE_RES},
            '{1'b1, CH_CR,   8'd1,  1'b1, BAD_SIZE_RES},
            '{1'b1, "1",     8'd1,  1'b0, NO_RES},
            '{1'b0, CH_CR,   8'd1,  1'b0, NO_RES},
            '{1'b0, "x",     8'd1,  1'b1, BAD_SIZE_RES},
            '{1'b0, "5",     8'd1,  1'b0, NO_RES},
            '{1'b1, "2",     8'd1,  1'b0, NO_RES},
            '{1'b0, CH_SEMI, 8'd1,  1'b0, NO_RES},
            '{1'b0, "x",     8'd3,  1'b0, NO_RES},
            '{1'b0, CH_CR,   8'd2,  1'b0, NO_RES},
            '{1'b0, CH_LF,   8'd1,  1'b0, NO_RES},
            '{1'b0, 8'h00,   8'd1,  1'b1, '{RK_PAYLOAD, 8'h00, 1'b0, ERR_NONE}},
            '{1'b0, 8'hFF,   8'd1,  1'b1, '{RK_PAYLOAD, 8'hFF, 1'b1, ERR_NONE}},
            '{1'b0, "z",     8'd1,  1'b1, CHUNK_END_RES},
            '{1'b1, "0",     8'd40, 1'b0, NO_RES},
            '{1'b0, "c",     8'd1,  1'b0, NO_RES},
            '{1'b0, CH_CR,   8'd1,  1'b0, NO_RES},
            '{1'b0, CH_LF,   8'd1,  1'b0, NO_RES},
            '{1'b0, 8'hA5,   8'd12, 1'b0, NO_RES},
            '{1'b0, CH_CR,   8'd1,  1'b0, NO_RES},
            '{1'b0, "q",     8'd1,  1'b1, CHUNK_END_RES},
            '{1'b1, "f",     8'd16, 1'b0, NO_RES},
            '{1'b0, "F",     8'd1,  1'b1, OVERFLOW_RES},
            '{1'b1, "0",     8'd1,  1'b0, NO_RES},
            '{1'b0, CH_CR,   8'd1,  1'b0, NO_RES},
            '{1'b0, CH_LF,   8'd1,  1'b1, FINISHED_RES}
        };
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(plan); i++)
            for (int j = 0; j < plan[i].reps; j++)
                send_byte(plan[i].rs && j == 0, plan[i].b,
                          plan[i].typed && j == plan[i].reps - 1, plan[i].want);
        wait_all_results();

        // random streams, each opened with restart
        while (live_items < LIVE_TARGET)
        begin
            make_stream();
            if ($urandom_range(99) < 10)
                stream_bytes[$urandom_range(0, stream_bytes.size() - 1)] =
                    8'($urandom_range(0, 255));
            for (int i = 0; i < stream_bytes.size(); i++)
            begin
                steady = live_items >= 700 && live_items < 1000;
                rs = (i == 0) || ($urandom_range(199) == 0);
                send_byte(rs, stream_bytes[i], 1'b0, NO_RES);
            end
            streams++;
            if (streams % 15 == 0) wait_all_results();
        end
        steady = 1'b0;

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
